/* src/mpq_pkg.sv */
// Shared types and constants for the max-priority queue of distinct keys.
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int KEY_W = 32;
    localparam int CAPACITY_DEF = 64;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_PUSHED = 3'd0,
        STATUS_EXISTS = 3'd1,
        STATUS_FULL   = 3'd2,
        STATUS_POPPED = 3'd3,
        STATUS_EMPTY  = 3'd4
    } status_t;

    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] popped_key;
        logic signed [KEY_W-1:0] top_key;
        logic                    top_valid;
    } res_t;

endpackage

/* src/max_priority_queue_unique_core.sv */
// Top level of the max-priority queue of distinct signed 32-bit keys.
// Usage:
// Each input item is one operation: s_tuser selects push (0) or pop (1) and
// s_tdata carries the key for a push. Each item gives exactly one result item
// on the m_ channel: m_tuser holds the status (pushed, exists, full, popped,
// empty) and m_tdata the popped key, the largest key still held and its valid
// flag. The keys live unordered in a single-port-read memory; every operation
// reads all held entries, one per cycle, to look for a duplicate on push or to
// find the slot of the maximum and the runner-up on pop. The largest key is
// kept in a register, so a push needs no maximum search.
// An accepted item passes through the scan of the held keys (skipped on an
// empty queue), a write state and a done state that loads the output
// register. s_tready is high only in the idle state, so the next item is taken
// only after the result of the previous one has been registered.
// A result waiting in the output register does not block the next item, but
// the following result waits until it is taken, and while it waits s_tready
// stays low. Reset (aresetn low at a clock edge) empties the queue at once; the
// memory needs no clearing pass.
`timescale 1ns / 1ps

module max_priority_queue_unique_core #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] new_key
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] popped_key, [63:32] top_key, [64] top_valid
    output logic [2:0]  m_tuser    // [2:0] status
);
    import mpq_pkg::*;

    localparam int AddrW = $clog2(CAPACITY);

    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic [KEY_W-1:0] rd_data;
    res_t             res;

    mpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser[0]),
        .in_key    (s_tdata),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    mpq_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tuser = res.status;
    assign m_tdata = {7'b0, res.top_valid, res.top_key, res.popped_key};

endmodule

/* src/mpq_store.sv */
// Key memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module mpq_store #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
    localparam int AddrW = $clog2(CAPACITY)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AddrW-1:0]           wr_addr,
    input  logic [mpq_pkg::KEY_W-1:0]  wr_data,
    input  logic                       rd_en,
    input  logic [AddrW-1:0]           rd_addr,
    output logic [mpq_pkg::KEY_W-1:0]  rd_data
);
    import mpq_pkg::*;

    logic [KEY_W-1:0] mem [CAPACITY];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/mpq_ctrl.sv */
// Sequencer: scans the key memory, updates it and the top key, and holds the result.
`timescale 1ns / 1ps

module mpq_ctrl #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
    localparam int AddrW = $clog2(CAPACITY),
    localparam int CntW = $clog2(CAPACITY + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_cmd,
    input  logic [mpq_pkg::KEY_W-1:0]  in_key,
    output logic                       res_valid,
    input  logic                       res_ready,
    output mpq_pkg::res_t              res,
    output logic                       wr_en,
    output logic [AddrW-1:0]           wr_addr,
    output logic [mpq_pkg::KEY_W-1:0]  wr_data,
    output logic                       rd_en,
    output logic [AddrW-1:0]           rd_addr,
    input  logic [mpq_pkg::KEY_W-1:0]  rd_data
);
    import mpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic             cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [KEY_W-1:0] top_reg, top_next;
    logic             top_valid_reg, top_valid_next;
    logic [CntW-1:0]  issue_reg, issue_next;
    logic             rv_reg, rv_next;
    logic [AddrW-1:0] rv_idx_reg, rv_idx_next;
    logic             found_reg, found_next;
    logic [AddrW-1:0] max_slot_reg, max_slot_next;
    logic [KEY_W-1:0] best_reg, best_next;
    logic             best_valid_reg, best_valid_next;
    logic [KEY_W-1:0] last_reg, last_next;
    status_t          status_reg, status_next;
    logic [KEY_W-1:0] popped_reg, popped_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    logic accept;
    logic last_beat;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign rd_en = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign rd_addr = issue_reg[AddrW-1:0];
    assign last_beat = rv_reg && (CntW'(rv_idx_reg) == count_reg - CntW'(1));

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        top_valid_next  = top_valid_reg;
        issue_next      = issue_reg;
        rv_next         = rd_en;
        rv_idx_next     = rd_addr;
        found_next      = found_reg;
        max_slot_next   = max_slot_reg;
        best_next       = best_reg;
        best_valid_next = best_valid_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        popped_next     = popped_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = max_slot_reg;
        wr_data         = last_reg;

        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next        = in_cmd;
                    key_next        = in_key;
                    issue_next      = '0;
                    found_next      = 1'b0;
                    best_next       = '0;
                    best_valid_next = 1'b0;
                    state_next      = (count_reg == '0) ? S_WRITE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    issue_next = issue_reg + CntW'(1);
                end
                if (rv_reg) begin
                    if (rd_data == key_reg) begin
                        found_next = 1'b1;
                    end
                    // Keys are distinct, so exactly one entry matches the top key.
                    if (rd_data == top_reg) begin
                        max_slot_next = rv_idx_reg;
                    end else if (!best_valid_reg ||
                                 ($signed(rd_data) > $signed(best_reg))) begin
                        best_next       = rd_data;
                        best_valid_next = 1'b1;
                    end
                    if (last_beat) begin
                        last_next  = rd_data;
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                popped_next = '0;
                state_next  = S_DONE;
                if (cmd_reg == CMD_PUSH) begin
                    if (found_reg) begin
                        status_next = STATUS_EXISTS;
                    end else if (count_reg == CntW'(CAPACITY)) begin
                        status_next = STATUS_FULL;
                    end else begin
                        wr_en       = 1'b1;
                        wr_addr     = count_reg[AddrW-1:0];
                        wr_data     = key_reg;
                        count_next  = count_reg + CntW'(1);
                        status_next = STATUS_PUSHED;
                        if (!top_valid_reg || ($signed(key_reg) > $signed(top_reg))) begin
                            top_next = key_reg;
                        end
                        top_valid_next = 1'b1;
                    end
                end else begin
                    if (count_reg == '0) begin
                        status_next = STATUS_EMPTY;
                    end else begin
                        // The last entry fills the hole left by the removed maximum.
                        wr_en          = 1'b1;
                        count_next     = count_reg - CntW'(1);
                        status_next    = STATUS_POPPED;
                        popped_next    = top_reg;
                        top_next       = best_reg;
                        top_valid_next = best_valid_reg;
                    end
                end
            end
            S_DONE: begin
                if (!res_valid_reg || res_ready) begin
                    res_valid_next       = 1'b1;
                    res_next.status      = status_reg;
                    res_next.popped_key  = popped_reg;
                    res_next.top_key     = top_valid_reg ? top_reg : '0;
                    res_next.top_valid   = top_valid_reg;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            top_reg        <= '0;
            top_valid_reg  <= 1'b0;
            rv_reg         <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            top_valid_reg  <= top_valid_next;
            rv_reg         <= rv_next;
            res_valid_reg  <= res_valid_next;
        end
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        issue_reg      <= issue_next;
        rv_idx_reg     <= rv_idx_next;
        found_reg      <= found_next;
        max_slot_reg   <= max_slot_next;
        best_reg       <= best_next;
        best_valid_reg <= best_valid_next;
        last_reg       <= last_next;
        status_reg     <= status_next;
        popped_reg     <= popped_next;
        res_reg        <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(CAPACITY))
        else $error("key count above capacity");

    a_top_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        top_valid_reg == (count_reg != '0))
        else $error("top valid disagrees with key count");

    a_write_moves_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> count_reg != $past(count_reg))
        else $error("memory write without a change of key count");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && (res_reg.status == STATUS_EMPTY) |-> !res_reg.top_valid)
        else $error("empty result shows a held key");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the max-priority queue of distinct signed keys.
`timescale 1ns / 1ps

module tb_top;
    import mpq_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;
    localparam int ITEMS = 850;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = DEPTH + 20;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef enum {PHASE_MIX, PHASE_FILL, PHASE_DRAIN} phase_t;

    // Keeps its own copy of the held keys and a FIFO of predicted results.
    class mpq_scoreboard;
        logic signed [KEY_W-1:0] held[$];
        res_t outstanding[$];
        int errors;
        int checked;
        int status_seen[5];
        int peak;

        function int largest_slot();
            int best;
            best = 0;
            for (int i = 1; i < held.size(); i++) begin
                if (held[i] > held[best]) best = i;
            end
            return best;
        endfunction

        function void note_item(logic cmd, logic signed [KEY_W-1:0] key);
            res_t r;
            int slot;
            bit found;
            r = '0;
            found = 1'b0;
            if (cmd == CMD_PUSH) begin
                foreach (held[i]) begin
                    if (held[i] == key) found = 1'b1;
                end
                if (found) begin
                    r.status = STATUS_EXISTS;
                end else if (held.size() >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    held.push_back(key);
                    r.status = STATUS_PUSHED;
                end
            end else if (held.size() == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                slot = largest_slot();
                r.popped_key = held[slot];
                held.delete(slot);
                r.status = STATUS_POPPED;
            end
            if (held.size() > 0) begin
                r.top_key = held[largest_slot()];
                r.top_valid = 1'b1;
            end
            if (held.size() > peak) peak = held.size();
            outstanding.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 30) $display("mismatch: %s", what);
        endtask

        task check_result(logic [2:0] st, logic [71:0] data);
            res_t exp;
            if (outstanding.size() == 0) begin
                report($sformatf("result with nothing outstanding, status %0d", st));
                return;
            end
            exp = outstanding.pop_front();
            checked++;
            status_seen[int'(exp.status)]++;
            if (st !== exp.status)
                report($sformatf("result %0d status %0d, want %0d", checked, st, exp.status));
            if (data[31:0] !== exp.popped_key)
                report($sformatf("result %0d popped_key %0d, want %0d", checked,
                                 $signed(data[31:0]), exp.popped_key));
            if (data[63:32] !== exp.top_key)
                report($sformatf("result %0d top_key %0d, want %0d", checked,
                                 $signed(data[63:32]), exp.top_key));
            if (data[64] !== exp.top_valid)
                report($sformatf("result %0d top_valid %0b, want %0b", checked,
                                 data[64], exp.top_valid));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [31:0] new_key
    logic [0:0]  s_tuser;     // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;     // [31:0] popped_key, [63:32] top_key, [64] top_valid
    logic [2:0]  m_tuser;     // [2:0] status

    mpq_scoreboard sb;
    int burst_left;
    int sent;
    int quiet_cycles;
    int ready_mode;
    int ready_left;

    max_priority_queue_unique_core #(
        .CAPACITY(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: stretches of always-ready, coin-flip, mostly-stalled and held-off.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(3);
            ready_left = (ready_mode == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
        end
        ready_left--;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(1));
            2: m_tready <= ($urandom_range(5) == 0);
            default: m_tready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_item(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_item(logic cmd, logic signed [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= key;
        do @(posedge aclk); while (!s_tready);
        sent++;
        @(negedge aclk);
    endtask

    // Mix of held keys (duplicates), a small clustered range, extremes and fresh values.
    function logic signed [KEY_W-1:0] pick_key(bit mostly_fresh);
        int r;
        r = $urandom_range(99);
        if (mostly_fresh && r < 80) return $urandom;
        if (r < 25 && sb.held.size() > 0) return sb.held[$urandom_range(sb.held.size() - 1)];
        if (r < 45) return int'($urandom_range(15)) - 8;
        if (r < 55) begin
            case ($urandom_range(3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_MIN + 1;
                default: return KEY_MAX - 1;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        phase_t phase;
        int len;
        int r;
        logic cmd;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        burst_left = 0;
        sent = 0;
        quiet_cycles = 0;
        ready_mode = 0;
        ready_left = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty pop, duplicates, both extremes, drain through to empty.
        send_item(CMD_POP, $urandom);
        send_item(CMD_PUSH, 0);
        send_item(CMD_PUSH, 0);
        send_item(CMD_PUSH, KEY_MIN);
        send_item(CMD_PUSH, KEY_MAX);
        send_item(CMD_PUSH, -1);
        send_item(CMD_PUSH, 1);
        send_item(CMD_POP, $urandom);
        send_item(CMD_PUSH, KEY_MAX);
        send_item(CMD_PUSH, KEY_MIN);
        send_item(CMD_PUSH, -1);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_PUSH, KEY_MIN);
        send_item(CMD_PUSH, KEY_MIN + 1);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);

        // Random phases; fill phases run the store into full and push duplicates there.
        while (sent < ITEMS) begin
            phase = phase_t'($urandom_range(2));
            len = (phase == PHASE_FILL) ? $urandom_range(70, 140) : $urandom_range(10, 80);
            for (int j = 0; j < len && sent < ITEMS; j++) begin
                r = $urandom_range(99);
                case (phase)
                    PHASE_FILL:  cmd = (r < 90) ? CMD_PUSH : CMD_POP;
                    PHASE_DRAIN: cmd = (r < 80) ? CMD_POP : CMD_PUSH;
                    default:     cmd = (r < 55) ? CMD_PUSH : CMD_POP;
                endcase
                send_item(cmd, (cmd == CMD_PUSH) ? pick_key(phase == PHASE_FILL)
                                                 : logic'($urandom) ? KEY_MIN : $urandom);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.outstanding.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d operations checked: %0d pushed, %0d duplicate, %0d full,",
                 sb.checked, sb.status_seen[STATUS_PUSHED], sb.status_seen[STATUS_EXISTS],
                 sb.status_seen[STATUS_FULL]);
        $display("%0d popped, %0d empty; peak occupancy %0d of %0d keys, %0d mismatches",
                 sb.status_seen[STATUS_POPPED], sb.status_seen[STATUS_EMPTY],
                 sb.peak, DEPTH, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
